### sv/rsch_pkg.sv
// shared types, constants and arithmetic helpers for the ray/sphere closest-hit block
package rsch_pkg;

  localparam int MaxSpheres = 16;
  localparam int SlotW = 4;
  localparam int CountW = 5;

  localparam logic [31:0] MISS_DISTANCE = 32'h7FFF_FFFF;
  localparam logic [31:0] MISS_COLOR = 32'h0000_00FF;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_NEAR = 3'd3;
  localparam logic [2:0] REG_FAR = 3'd4;
  localparam logic [2:0] REG_ACTIVE = 3'd5;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TRACE = 1'b1;

  typedef struct packed {
    logic kind;
    logic [3:0] slot;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0] radius;
    logic [31:0] sphere_color;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } item_in_t;

  typedef struct packed {
    logic hit;
    logic [3:0] hit_slot;
    logic signed [31:0] hit_distance;
    logic [31:0] pixel_color;
  } item_out_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0] r;
    logic [31:0] color;
  } sphere_t;

  // clamp a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v > 34'sh0_7FFF_FFFF) res = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  // clamp a wide sum to 32 bits
  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    logic signed [31:0] res;
    if (v > 50'sh7FFF_FFFF) res = 32'sh7FFF_FFFF;
    else if (v < -50'sh8000_0000) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

endpackage

### sv/rsch_div.sv
// sequential restoring divider, floor quotient of a signed dividend by a positive divisor
module rsch_div
  import rsch_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic signed [65:0]  num,
  input  logic [31:0]         den,
  output logic                done,
  output logic signed [66:0]  quot
);

  logic [6:0]  cnt;
  logic        running;
  logic        neg;
  logic [65:0] n_mag;
  logic [65:0] q;
  logic [32:0] rem;
  logic [32:0] trial;
  logic [65:0] q_adj;

  assign trial = {rem[31:0], n_mag[65]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= 7'd66;
      end else if (running) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= num[65];
      n_mag <= num[65] ? 66'(-num) : 66'(num);
      rem <= '0;
      q <= '0;
    end else if (running) begin
      n_mag <= {n_mag[64:0], 1'b0};
      if (!trial[32]) begin
        rem <= trial;
        q <= {q[64:0], 1'b1};
      end else begin
        rem <= {rem[31:0], n_mag[65]};
        q <= {q[64:0], 1'b0};
      end
    end
  end

  // negative dividend rounds toward minus infinity
  assign q_adj = q + 66'((rem != '0) ? 1 : 0);
  assign quot = neg ? -$signed({1'b0, q_adj}) : $signed({1'b0, q});

endmodule

### sv/ray_sphere_closest_hit.sv
// top level of the ray/sphere closest-hit block
//
// usage: pulse start with an item while busy is low. a load item (kind 0)
// writes one slot of the sphere memory; a trace item (kind 1) casts a ray from
// the configured origin along dir and tests slots 0 up to active_spheres-1 (at most 16).
// each item gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so nothing is held back.
// a load passes through the load state and the output state to its result. a
// trace first forms a, then for each slot reads the sphere, forms the offset
// from the center, the products, h, c and the discriminant, runs a serial
// square root and two divisions on one shared divider; a slot with a negative
// discriminant skips the root iterations and the divisions. the output state
// then gives the result. busy falls in the result cycle, so the next item can
// be taken at the edge ending it.
// config writes go through cfg_we, cfg_index and cfg_data and must only come
// while the block is idle.
// reset (rst, synchronous) restores the control and config registers to their defaults; the
// sphere memory is not cleared and must be loaded before it is traced.
module ray_sphere_closest_hit
  import rsch_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_in_t    item_in,
  output logic        done,
  output item_out_t   item_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_A1    = 4'd1;
  localparam logic [3:0] ST_A2    = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_CO    = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_DISC  = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_DIV0  = 4'd9;
  localparam logic [3:0] ST_DIV1  = 4'd10;
  localparam logic [3:0] ST_NEXT  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;
  localparam logic [3:0] ST_LOAD  = 4'd13;

  logic [3:0] state;

  logic signed [31:0] origin_x, origin_y, origin_z, near_limit, far_limit;
  logic [CountW-1:0]  active_spheres;

  sphere_t mem [MaxSpheres];
  sphere_t rd;

  logic signed [31:0] dx, dy, dz;
  logic signed [31:0] a;
  logic [CountW-1:0]  idx;
  logic [CountW-1:0]  n_lim;
  logic signed [31:0] ox, oy, oz;
  logic signed [63:0] p0, p1, p2, p3, p4, p5, p6;
  logic signed [31:0] h, c;
  logic signed [64:0] disc;
  logic [31:0]        sq_res;
  logic [63:0]        sq_rem;
  logic [5:0]         sq_cnt;
  logic               found;
  logic signed [31:0] best_t;
  logic [SlotW-1:0]   best_slot;
  logic [31:0]        best_color;
  logic [SlotW-1:0]   rd_slot;

  logic               div_go, div_done;
  logic signed [65:0] div_num;
  logic signed [66:0] div_q;

  // floor(p / 2^16) is an arithmetic shift
  function automatic logic signed [47:0] fsh(input logic signed [63:0] p);
    return p[63:16];
  endfunction

  rsch_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (a),
    .done (div_done),
    .quot (div_q)
  );

  assign busy = (state != ST_IDLE);
  assign n_lim = (active_spheres > CountW'(MaxSpheres)) ? CountW'(MaxSpheres) : active_spheres;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      near_limit <= 32'sd65536;
      far_limit <= 32'sh7FFF_FFFF;
      active_spheres <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        REG_NEAR:     near_limit <= cfg_data;
        REG_FAR:      far_limit <= cfg_data;
        REG_ACTIVE:   active_spheres <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // sphere memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && item_in.kind == KIND_LOAD) begin
      mem[item_in.slot] <= '{cx: item_in.center_x, cy: item_in.center_y,
                            cz: item_in.center_z, r: {1'b0, item_in.radius},
                            color: item_in.sphere_color};
    end
    rd <= mem[rd_slot];
  end
  assign rd_slot = idx[SlotW-1:0];

  logic signed [49:0] sum_a, sum_h, sum_c;
  logic [63:0]        sq_test;
  logic               t_ok;
  logic signed [66:0] t_val;

  assign sum_a = 50'(fsh(p0)) + 50'(fsh(p1)) + 50'(fsh(p2));
  assign sum_h = 50'(fsh(p0)) + 50'(fsh(p1)) + 50'(fsh(p2));
  assign sum_c = 50'(fsh(p3)) + 50'(fsh(p4)) + 50'(fsh(p5)) - 50'(fsh(p6));
  // (2*root + bit) * bit, the root holding only the bits above this one
  assign sq_test = ({32'd0, sq_res} << (sq_cnt + 6'd1)) + (64'd1 << {sq_cnt, 1'b0});
  assign t_val = div_q;
  assign t_ok = (t_val >= 67'(near_limit)) && (t_val <= 67'(far_limit)) &&
                (!found || t_val < 67'(best_t));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done <= 1'b0;
      div_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            found <= 1'b0;
            best_t <= MISS_DISTANCE;
            best_slot <= '0;
            best_color <= MISS_COLOR;
            idx <= '0;
            dx <= item_in.dir_x;
            dy <= item_in.dir_y;
            dz <= item_in.dir_z;
            state <= (item_in.kind == KIND_TRACE) ? ST_A1 : ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_OUT;
        ST_A1: begin
          p0 <= dx * dx;
          p1 <= dy * dy;
          p2 <= dz * dz;
          state <= ST_A2;
        end
        ST_A2: begin
          a <= sat50(sum_a);
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (idx >= n_lim || a <= 0) state <= ST_OUT;
          else state <= ST_RD;
        end
        ST_RD: state <= ST_CO;
        ST_CO: begin
          ox <= sat34(34'(origin_x) - 34'(rd.cx));
          oy <= sat34(34'(origin_y) - 34'(rd.cy));
          oz <= sat34(34'(origin_z) - 34'(rd.cz));
          state <= ST_MUL;
        end
        ST_MUL: begin
          p0 <= ox * dx;
          p1 <= oy * dy;
          p2 <= oz * dz;
          p3 <= ox * ox;
          p4 <= oy * oy;
          p5 <= oz * oz;
          p6 <= $signed(rd.r) * $signed(rd.r);
          state <= ST_SUM;
        end
        ST_SUM: begin
          h <= sat50(sum_h);
          c <= sat50(sum_c);
          state <= ST_DISC;
        end
        ST_DISC: begin
          disc <= 65'(h * h) - 65'(a * c);
          state <= ST_SQRT;
          sq_cnt <= 6'd32;
          sq_res <= '0;
        end
        ST_SQRT: begin
          if (sq_cnt == 6'd32) begin
            if (disc < 0) begin
              idx <= idx + 1'b1;
              state <= ST_NEXT;
            end else begin
              sq_rem <= disc[63:0];
              sq_cnt <= 6'd31;
            end
          end else begin
            if (sq_rem >= sq_test) begin
              sq_rem <= sq_rem - sq_test;
              sq_res <= sq_res | (32'd1 << sq_cnt[4:0]);
            end
            if (sq_cnt == 6'd0) begin
              state <= ST_DIV0;
              div_go <= 1'b1;
            end
            sq_cnt <= sq_cnt - 6'd1;
          end
        end
        ST_DIV0: begin
          if (div_done) begin
            if (t_ok) begin
              found <= 1'b1;
              best_t <= t_val[31:0];
              best_slot <= idx[SlotW-1:0];
              best_color <= rd.color;
            end
            div_go <= 1'b1;
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done && !div_go) begin
            if (t_ok) begin
              found <= 1'b1;
              best_t <= t_val[31:0];
              best_slot <= idx[SlotW-1:0];
              best_color <= rd.color;
            end
            idx <= idx + 1'b1;
            state <= ST_NEXT;
          end
        end
        ST_OUT: begin
          done <= 1'b1;
          item_out <= '{hit: found, hit_slot: best_slot,
                        hit_distance: best_t, pixel_color: best_color};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // root numerators; the root bit set in sq_res on the last iteration is folded in
  logic signed [65:0] s_ext;
  assign s_ext = 66'($signed({1'b0, sq_res}));
  assign div_num = (state == ST_SQRT || state == ST_DIV0 && !div_done) ?
                   ((-66'(h) - s_ext) <<< 16) : ((-66'(h) + s_ext) <<< 16);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == ST_IDLE)
    else $error("result not shown while idle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
                                 (state == ST_IDLE && start) |=> busy)
    else $error("busy low after accept");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
                                (state == ST_RD) |-> idx < n_lim)
    else $error("slot index beyond active count");

endmodule

### verif/ray_sphere_closest_hit_tb.sv
// self-checking testbench for the ray/sphere closest-hit block
`timescale 1ns / 100ps

module ray_sphere_closest_hit_tb;
  import rsch_pkg::*;

  localparam int Unit = 65536;
  localparam int StallLimit = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_in_t item_in = '0;
  logic done;
  item_out_t item_out;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ray_sphere_closest_hit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .done(done), .item_out(item_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  item_in_t pending_items[$];
  item_out_t expected_hits[$];
  item_in_t sphere_copy[MaxSpheres];
  longint org_x = 0, org_y = 0, org_z = 0;
  longint near_lim = 65536, far_lim = 64'sd2147483647;
  logic [4:0] n_active = '0;
  int idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  task automatic queue_item(item_in_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(x*y / 2^16)
  function automatic longint qmul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> 16;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if (n < 0 && (n % d) != 0) q = q - 1;
    return q;
  endfunction

  function automatic longint root_floor(longint v);
    logic [63:0] x, res, bitv;
    x = v;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic item_out_t nearest_hit(item_in_t it);
    item_out_t r;
    longint dx, dy, dz, a, ox, oy, oz, h, c, disc, s, t;
    longint roots[2];
    int n;
    logic found;
    r.hit = 1'b0;
    r.hit_slot = '0;
    r.hit_distance = MISS_DISTANCE;
    r.pixel_color = MISS_COLOR;
    if (it.kind == KIND_LOAD) return r;
    found = 1'b0;
    dx = it.dir_x;
    dy = it.dir_y;
    dz = it.dir_z;
    a = sat32(qmul(dx, dx) + qmul(dy, dy) + qmul(dz, dz));
    n = (n_active > MaxSpheres) ? MaxSpheres : n_active;
    for (int i = 0; i < n && a > 0; i++) begin
      ox = sat32(org_x - longint'(sphere_copy[i].center_x));
      oy = sat32(org_y - longint'(sphere_copy[i].center_y));
      oz = sat32(org_z - longint'(sphere_copy[i].center_z));
      h = sat32(qmul(ox, dx) + qmul(oy, dy) + qmul(oz, dz));
      c = sat32(qmul(ox, ox) + qmul(oy, oy) + qmul(oz, oz)
                - qmul(longint'(sphere_copy[i].radius), longint'(sphere_copy[i].radius)));
      disc = h * h - a * c;
      if (disc < 0) continue;
      s = root_floor(disc);
      roots[0] = floor_div((-h - s) * 65536, a);
      roots[1] = floor_div((-h + s) * 65536, a);
      for (int k = 0; k < 2; k++) begin
        t = roots[k];
        if (t >= near_lim && t <= far_lim && (!found || t < longint'(r.hit_distance))) begin
          found = 1'b1;
          r.hit = 1'b1;
          r.hit_slot = i[3:0];
          r.hit_distance = t[31:0];
          r.pixel_color = sphere_copy[i].sphere_color;
        end
      end
    end
    return r;
  endfunction

  // driver: offer the oldest pending item, with random sender gaps
  always @(negedge clk) begin
    if (!rst && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      item_in <= pending_items[0];
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (start && !busy) begin
        expected_hits = {expected_hits, nearest_hit(item_in)};
        if (item_in.kind == KIND_LOAD) sphere_copy[item_in.slot] = item_in;
        void'(pending_items.pop_front());
        quiet_cycles = 0;
      end
      if (done) begin
        quiet_cycles = 0;
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, item_out);
        end else begin
          item_out_t e;
          e = expected_hits.pop_front();
          if (e.hit !== item_out.hit) begin
            errors++;
            $display("%0t: hit exp %h got %h", $time, e.hit, item_out.hit);
          end
          if (e.hit_slot !== item_out.hit_slot) begin
            errors++;
            $display("%0t: hit_slot exp %h got %h", $time, e.hit_slot, item_out.hit_slot);
          end
          if (e.hit_distance !== item_out.hit_distance) begin
            errors++;
            $display("%0t: hit_distance exp %h got %h", $time, e.hit_distance,
                     item_out.hit_distance);
          end
          if (e.pixel_color !== item_out.pixel_color) begin
            errors++;
            $display("%0t: pixel_color exp %h got %h", $time, e.pixel_color,
                     item_out.pixel_color);
          end
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("ray_sphere_closest_hit regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ORIGIN_X: org_x = longint'(signed'(val));
      REG_ORIGIN_Y: org_y = longint'(signed'(val));
      REG_ORIGIN_Z: org_z = longint'(signed'(val));
      REG_NEAR: near_lim = longint'(signed'(val));
      REG_FAR: far_lim = longint'(signed'(val));
      REG_ACTIVE: n_active = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_hits.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic item_in_t sphere_item(logic [3:0] slot);
    item_in_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.slot = slot;
    it.center_x = span(-4 * Unit, 4 * Unit);
    it.center_y = span(-4 * Unit, 4 * Unit);
    it.center_z = span(4 * Unit, 30 * Unit);
    it.radius = 31'(span(Unit / 2, 4 * Unit));
    it.sphere_color = $urandom;
    it.dir_x = $urandom;
    return it;
  endfunction

  function automatic item_in_t ray_item();
    item_in_t it;
    it = '0;
    it.kind = KIND_TRACE;
    it.slot = 4'($urandom);
    it.dir_x = span(-Unit / 2, Unit / 2);
    it.dir_y = span(-Unit / 2, Unit / 2);
    it.dir_z = span(Unit / 2, 2 * Unit);
    it.radius = 31'($urandom);
    return it;
  endfunction

  function automatic item_in_t noise_item(logic kind);
    item_in_t it;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_in_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  initial begin
    item_in_t it;
    int phase_active;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every slot gets loaded before any trace reads it
    for (int i = 0; i < MaxSpheres; i++) queue_item(sphere_item(4'(i)));
    it = sphere_item(15);
    it.center_x = 32'sh8000_0000;
    it.center_y = 32'sh7FFF_FFFF;
    it.radius = 31'h7FFF_FFFF;
    it.sphere_color = 32'hFFFF_FFFF;
    queue_item(it);
    drain();
    write_reg(REG_ACTIVE, 5'h1F);  // saturates to the table size
    queue_item(ray_item());
    it = ray_item();
    it.dir_x = 0; it.dir_y = 0; it.dir_z = 0;  // zero-length direction
    queue_item(it);
    it.dir_x = 32'sh8000_0000; it.dir_y = 32'sh7FFF_FFFF; it.dir_z = 32'sh8000_0000;
    queue_item(it);
    drain();
    // identical spheres: the lower slot wins the tie
    it = sphere_item(0);
    it.center_x = 0; it.center_y = 0; it.center_z = 10 * Unit; it.radius = 31'(2 * Unit);
    queue_item(it);
    it.slot = 4'd1;
    it.sphere_color = ~it.sphere_color;
    queue_item(it);
    drain();
    write_reg(REG_ACTIVE, 2);
    it = ray_item();
    it.dir_x = 0; it.dir_y = 0; it.dir_z = Unit;
    queue_item(it);
    drain();
    // far below near: all traces miss
    write_reg(REG_NEAR, 32'h7FFF_FFFF);
    write_reg(REG_FAR, 32'h8000_0000);
    queue_item(it);
    drain();
    write_reg(REG_NEAR, 32'h8000_0000);
    write_reg(REG_FAR, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_Z, 32'h8000_0000);
    queue_item(it);
    queue_item(noise_item(KIND_TRACE));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 50;
        default: idle_pct = 21;
      endcase
      write_reg(REG_ORIGIN_X, span(-Unit, Unit));
      write_reg(REG_ORIGIN_Y, span(-Unit, Unit));
      write_reg(REG_ORIGIN_Z, span(-2 * Unit, Unit));
      write_reg(REG_NEAR, (ph == 3) ? 32'h8000_0000 : span(0, Unit));
      write_reg(REG_FAR, (ph == 4) ? span(5 * Unit, 15 * Unit) : 32'h7FFF_FFFF);
      phase_active = (ph == 5) ? 16 : span(1, 4);
      write_reg(REG_ACTIVE, phase_active);
      for (int k = 0; k < ((ph == 5) ? 40 : 165); k++) begin
        case ($urandom_range(9))
          0: queue_item(noise_item(KIND_LOAD));
          1: queue_item(noise_item(KIND_TRACE));
          2, 3, 4: queue_item(sphere_item(4'($urandom_range(15))));
          default: queue_item(ray_item());
        endcase
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ray_sphere_closest_hit regression: pass");
    end else begin
      $display("ray_sphere_closest_hit regression: fail");
    end
    $finish;
  end

endmodule
